/* src/kdh_pkg.sv */
// kdh_pkg: widths and constants shared by the key dedup hash set
// no dependencies; compiled first
`default_nettype none
package kdh_pkg;
	localparam int KEY_W = 32;
	localparam logic [KEY_W-1:0] HASH_MUL = 32'h045d_9f3b;
	localparam int HASH_SHIFT = 16;
	localparam int PROBE_SHIFT = 5;

	// one round of the key mixer: xor-shift then multiply, modulo 2^32
	function automatic logic [KEY_W-1:0] mix_round(input logic [KEY_W-1:0] x);
		logic [KEY_W-1:0] t;
		t = (x >> HASH_SHIFT) ^ x;
		return t * HASH_MUL;
	endfunction
endpackage
`default_nettype wire

/* src/kdh_key_if.sv */
// kdh_key_if: valid/ready channel carrying one key per request
// depends on kdh_pkg
`default_nettype none
interface kdh_key_if
	import kdh_pkg::*;
();
	logic valid;
	logic ready;
	logic [KEY_W-1:0] key;

	modport source(output valid, output key, input ready);
	modport sink(input valid, input key, output ready);
endinterface
`default_nettype wire

/* src/kdh_res_if.sv */
// kdh_res_if: valid/ready channel carrying one lookup result per request
// depends on kdh_pkg
`default_nettype none
interface kdh_res_if
	import kdh_pkg::*;
();
	logic valid;
	logic ready;
	logic [KEY_W-1:0] key_out;
	logic is_new;
	logic table_full;
	logic ignored;

	modport source(output valid, output key_out, output is_new, output table_full,
		output ignored, input ready);
	modport sink(input valid, input key_out, input is_new, input table_full,
		input ignored, output ready);
endinterface
`default_nettype wire

/* src/kdh_ram.sv */
// kdh_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module kdh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* src/key_dedup_hash_set.sv */
// key_dedup_hash_set: set of 32-bit keys in an open-addressed table with perturb probing
// depends on kdh_pkg, kdh_key_if, kdh_res_if and kdh_ram
//
// usage:
//   keys    : valid/ready input, one 32-bit key per request
//   results : valid/ready output, one result per key: key_out echoes the key,
//             is_new marks a first occurrence (now stored), table_full marks a key
//             that found no empty slot in TABLE_DEPTH probes (not stored),
//             ignored marks a zero key (never stored)
//   one key is worked on at a time. a nonzero key is hashed by two registered
//   32x32 multiplies, then each probe reads the ram (registered read) and then
//   compares and writes back; finally the output register is loaded and the
//   block returns to idle. a zero key skips hashing and probing.
//   after reset the table is swept to zero, one slot a cycle; keys.ready stays
//   low during the sweep.
//   the output register lets a new key be accepted while a result waits; if the
//   receiver stalls, the next result is held back until the register frees up.
`default_nettype none
module key_dedup_hash_set
	import kdh_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input wire logic  clk,
	input wire logic  arst_n,
	kdh_key_if.sink   keys,
	kdh_res_if.source results
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [AW:0] DEPTH_C = (AW + 1)'(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MIX1,
		ST_MIX2,
		ST_PROBE,
		ST_CHECK,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] mix_q;
	logic [KEY_W-1:0] perturb_q;
	logic [AW-1:0] pos_q;
	logic [AW:0] cnt_q;
	logic new_q;
	logic full_q;
	logic ign_q;
	logic out_valid_q;
	logic [KEY_W-1:0] out_key_q;
	logic out_new_q;
	logic out_full_q;
	logic out_ign_q;

	logic [KEY_W-1:0] perturb_n;
	logic [AW-1:0] pos_n;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [KEY_W-1:0] ram_wdata;
	logic [KEY_W-1:0] rd_data;
	logic slot_empty;
	logic slot_hit;
	logic out_free;

	assign perturb_n = perturb_q >> PROBE_SHIFT;
	assign pos_n = (pos_q << 2) + pos_q + perturb_n[AW-1:0] + AW'(1);
	assign slot_empty = (rd_data == '0);
	assign slot_hit = (rd_data == key_q);
	assign out_free = !out_valid_q || results.ready;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = key_q;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_CHECK && slot_empty) begin
			ram_we = 1'b1;
		end
	end

	kdh_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(pos_n),
		.rdata(rd_data)
	);

	assign keys.ready = (state_q == ST_IDLE);
	assign results.valid = out_valid_q;
	assign results.key_out = out_key_q;
	assign results.is_new = out_new_q;
	assign results.table_full = out_full_q;
	assign results.ignored = out_ign_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			key_q <= '0;
			mix_q <= '0;
			perturb_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
			new_q <= 1'b0;
			full_q <= 1'b0;
			ign_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_key_q <= '0;
			out_new_q <= 1'b0;
			out_full_q <= 1'b0;
			out_ign_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (keys.valid) begin
						key_q <= keys.key;
						mix_q <= mix_round(keys.key);
						new_q <= 1'b0;
						full_q <= 1'b0;
						ign_q <= (keys.key == '0);
						state_q <= (keys.key == '0) ? ST_FINISH : ST_MIX1;
					end
				end
				ST_MIX1: begin
					mix_q <= mix_round(mix_q);
					state_q <= ST_MIX2;
				end
				ST_MIX2: begin
					perturb_q <= (mix_q >> HASH_SHIFT) ^ mix_q;
					pos_q <= '0;
					cnt_q <= '0;
					state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					perturb_q <= perturb_n;
					pos_q <= pos_n;
					cnt_q <= cnt_q + (AW + 1)'(1);
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (slot_empty) begin
						new_q <= 1'b1;
						state_q <= ST_FINISH;
					end else if (slot_hit) begin
						state_q <= ST_FINISH;
					end else if (cnt_q == DEPTH_C) begin
						full_q <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_PROBE;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_key_q <= key_q;
						out_new_q <= new_q;
						out_full_q <= full_q;
						out_ign_q <= ign_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_ignored_iff_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.ignored == (results.key_out == '0)))
		else $error("ignored flag does not match a zero key");

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> $countones({results.is_new, results.table_full,
			results.ignored}) <= 1)
		else $error("more than one outcome flag set");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("probe count ran past the table depth");

	a_hold_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=> results.valid && $stable(results.key_out))
		else $error("result changed while stalled");
endmodule
`default_nettype wire

/* tb/tb_key_dedup_hash_set.sv */
// tb_key_dedup_hash_set: self-checking bench for the key dedup hash set
// keeps a shadow table of the slots and checks every result in order
// depends on kdh_pkg, kdh_key_if, kdh_res_if and key_dedup_hash_set
`default_nettype none
module tb_key_dedup_hash_set;
	import kdh_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int TOTAL_KEYS = 1950;
	localparam int CALM_TAIL = 150;
	localparam longint CYCLE_LIMIT = 64'd12_000_000;

	typedef struct {
		logic [KEY_W-1:0] key;
		bit drain_first;
	} key_req_t;

	typedef struct {
		logic [KEY_W-1:0] key_out;
		logic is_new;
		logic table_full;
		logic ignored;
		longint accepted_at;
	} verdict_t;

	logic clk;
	logic arst_n;

	kdh_key_if keys_ch();
	kdh_res_if res_ch();

	key_dedup_hash_set #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.keys(keys_ch),
		.results(res_ch)
	);

	logic [KEY_W-1:0] shadow_slots [TABLE_DEPTH];
	key_req_t key_backlog [$];
	verdict_t pending_verdicts [$];
	bit issued [logic [KEY_W-1:0]];
	logic [KEY_W-1:0] issued_q [$];

	int queued_n;
	int accepted_n;
	int results_n;
	int fault_n;
	int src_gap;
	int snk_gap;
	int src_pct;
	int snk_pct;
	longint cycle_n;

	key_req_t next_req;
	verdict_t seen;
	verdict_t want;
	verdict_t oldest;
	logic [KEY_W-1:0] anchor_slot;
	logic [KEY_W-1:0] cand;
	logic [KEY_W-1:0] fresh;
	logic [KEY_W-1:0] colliders [3];
	int found;
	int pick;
	int fresh_pct;

	function automatic logic [KEY_W-1:0] scramble(input logic [KEY_W-1:0] v);
		logic [KEY_W-1:0] t;
		t = v;
		repeat (2) t = ((t >> HASH_SHIFT) ^ t) * HASH_MUL;
		return (t >> HASH_SHIFT) ^ t;
	endfunction

	function automatic verdict_t dedup_lookup(input logic [KEY_W-1:0] k);
		verdict_t v;
		logic [KEY_W-1:0] perturb;
		logic [KEY_W-1:0] pos;
		int idx;
		int n;
		bit done;
		v.key_out = k;
		v.is_new = 1'b0;
		v.table_full = 1'b0;
		v.ignored = (k == '0);
		v.accepted_at = 0;
		if (k != '0) begin
			v.table_full = 1'b1;
			perturb = scramble(k);
			pos = '0;
			n = 0;
			done = 0;
			while (!done && n < TABLE_DEPTH) begin
				perturb = perturb >> PROBE_SHIFT;
				pos = pos * 5 + perturb + 1;
				idx = int'(pos & (TABLE_DEPTH - 1));
				if (shadow_slots[idx] == '0) begin
					shadow_slots[idx] = k;
					v.is_new = 1'b1;
					v.table_full = 1'b0;
					done = 1;
				end else if (shadow_slots[idx] == k) begin
					v.table_full = 1'b0;
					done = 1;
				end
				n++;
			end
		end
		return v;
	endfunction

	task automatic queue_key(input logic [KEY_W-1:0] k, input bit drain);
		key_req_t r;
		r.key = k;
		r.drain_first = drain;
		key_backlog.push_back(r);
		queued_n++;
		if (k != '0 && !issued.exists(k)) begin
			issued[k] = 1;
			issued_q.push_back(k);
		end
	endtask

	task automatic note_fault(input string msg);
		fault_n++;
		if (fault_n <= 10)
			$display("%s", msg);
	endtask

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 35;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// request driver: holds valid until accepted, predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_ch.valid <= 1'b0;
			keys_ch.key <= '0;
			src_gap = 0;
		end else begin
			if (keys_ch.valid && keys_ch.ready) begin
				want = dedup_lookup(keys_ch.key);
				want.accepted_at = $time;
				pending_verdicts.push_back(want);
				accepted_n++;
				if (accepted_n % 100 == 0)
					src_pct = pick_pct();
			end
			if (!(keys_ch.valid && !keys_ch.ready)) begin
				if (src_gap > 0) begin
					src_gap--;
					keys_ch.valid <= 1'b0;
				end else if (key_backlog.size() == 0 ||
						(key_backlog[0].drain_first && pending_verdicts.size() != 0)) begin
					keys_ch.valid <= 1'b0;
				end else if (accepted_n < TOTAL_KEYS - CALM_TAIL &&
						$urandom_range(0, 99) < src_pct) begin
					src_gap = $urandom_range(0, 7);
					keys_ch.valid <= 1'b0;
				end else begin
					next_req = key_backlog.pop_front();
					keys_ch.valid <= 1'b1;
					keys_ch.key <= next_req.key;
				end
			end
		end
	end

	// result monitor: compares each accepted result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				results_n++;
				if (results_n % 100 == 0)
					snk_pct = pick_pct();
				seen.key_out = res_ch.key_out;
				seen.is_new = res_ch.is_new;
				seen.table_full = res_ch.table_full;
				seen.ignored = res_ch.ignored;
				if (pending_verdicts.size() == 0 || pending_verdicts[0].accepted_at == $time) begin
					note_fault($sformatf("unexpected result: key %h new %0b full %0b ign %0b",
						seen.key_out, seen.is_new, seen.table_full, seen.ignored));
				end else begin
					oldest = pending_verdicts.pop_front();
					if (seen.key_out !== oldest.key_out || seen.is_new !== oldest.is_new ||
							seen.table_full !== oldest.table_full ||
							seen.ignored !== oldest.ignored)
						note_fault($sformatf(
							"mismatch: expected key %h new %0b full %0b ign %0b, got key %h new %0b full %0b ign %0b",
							oldest.key_out, oldest.is_new, oldest.table_full, oldest.ignored,
							seen.key_out, seen.is_new, seen.table_full, seen.ignored));
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				res_ch.ready <= 1'b0;
			end else if (results_n < TOTAL_KEYS - CALM_TAIL && $urandom_range(0, 99) < snk_pct) begin
				snk_gap = $urandom_range(0, 7);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_n++;
		if (cycle_n >= CYCLE_LIMIT) begin
			$display("tb_key_dedup_hash_set: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		queued_n = 0;
		accepted_n = 0;
		results_n = 0;
		fault_n = 0;
		cycle_n = 0;
		src_pct = 10;
		snk_pct = 10;
		foreach (shadow_slots[i])
			shadow_slots[i] = '0;

		// extremes, zero keys and repeats
		queue_key(32'h0000_0000, 0);
		queue_key(32'hffff_ffff, 0);
		queue_key(32'h0000_0001, 0);
		queue_key(32'h8000_0000, 0);
		queue_key(32'hffff_ffff, 0);
		queue_key(32'h0000_0000, 0);
		queue_key(32'h0000_0001, 0);
		queue_key(32'haaaa_aaaa, 0);
		queue_key(32'h5555_5555, 0);
		queue_key(32'h7fff_ffff, 0);
		queue_key(32'h0001_0000, 0);
		queue_key(32'h0000_ffff, 0);
		queue_key(32'hc0a8_0101, 0);
		queue_key(32'h5555_5555, 0);
		queue_key(32'h8000_0000, 0);

		// keys landing on the same first slot force a probe chain
		anchor_slot = ((scramble(32'hc0a8_0101) >> PROBE_SHIFT) + 1) & (TABLE_DEPTH - 1);
		found = 0;
		cand = 32'h0a00_0001;
		while (found < 3) begin
			if ((((scramble(cand) >> PROBE_SHIFT) + 1) & (TABLE_DEPTH - 1)) == anchor_slot) begin
				colliders[found] = cand;
				queue_key(cand, 0);
				found++;
			end
			cand++;
		end
		queue_key(colliders[2], 0);
		queue_key(colliders[0], 0);
		queue_key(32'hc0a8_0101, 0);
		queue_key(32'h0000_0000, 0);

		// random part: fresh keys fill the table, then mostly repeats once it is full
		while (queued_n < TOTAL_KEYS) begin
			fresh_pct = (issued_q.size() < TABLE_DEPTH) ? 65 : 15;
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				queue_key('0, (queued_n % 500) == 0);
			end else if (pick < 4 + fresh_pct || issued_q.size() == 0) begin
				do begin
					if ($urandom_range(0, 9) < 3)
						fresh = {16'h0a00, 16'($urandom)};
					else
						fresh = $urandom;
				end while (fresh == '0 || issued.exists(fresh));
				queue_key(fresh, (queued_n % 500) == 0);
			end else begin
				queue_key(issued_q[$urandom_range(0, issued_q.size() - 1)],
					(queued_n % 500) == 0);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (accepted_n == TOTAL_KEYS);
		wait (pending_verdicts.size() == 0);
		repeat (64) @(posedge clk);
		if (fault_n == 0 && pending_verdicts.size() == 0) begin
			$display("tb_key_dedup_hash_set: done, clean");
		end else begin
			$display("tb_key_dedup_hash_set: done, errors");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
src/kdh_pkg.sv
src/kdh_key_if.sv
src/kdh_res_if.sv
src/kdh_ram.sv
src/key_dedup_hash_set.sv
tb/tb_key_dedup_hash_set.sv
